[hw/rtl/aip_pkg.sv]
// Package for the ASCII integer parser: phase and radix codes, the parse
// state record and the character classification functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package aip_pkg;

  typedef enum logic [3:0] {
    PH_START  = 4'b0001,
    PH_SIGN   = 4'b0010,
    PH_ZERO   = 4'b0100,
    PH_DIGITS = 4'b1000
  } phase_t;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_HEX = 2'd1,
    RADIX_OCT = 2'd2,
    RADIX_BIN = 2'd3
  } radix_t;

  typedef struct packed {
    phase_t      phase;
    logic        negative;
    radix_t      radix;
    logic [31:0] accum;
    logic        failed;
  } parse_state_t;

  typedef struct packed {
    logic   valid;
    radix_t radix;
  } prefix_t;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_LO_D  = 8'h64;
  localparam logic [7:0] CH_LO_O  = 8'h6F;
  localparam logic [7:0] CH_LO_B  = 8'h62;

  // Digit value 0..15, or 16 for a byte that is not a hex digit.
  localparam logic [4:0] DIGIT_NONE = 5'd16;

  localparam logic [35:0] LIMIT_POS = 36'h0_FFFF_FFFF;
  localparam logic [35:0] LIMIT_NEG = 36'h0_8000_0000;

  localparam parse_state_t STATE_RESET = '{
    phase:    PH_START,
    negative: 1'b0,
    radix:    RADIX_DEC,
    accum:    32'd0,
    failed:   1'b0
  };

  function automatic logic [4:0] digit_value(input logic [7:0] ch);
    logic [7:0] off;
    off = 8'd0;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      off = ch - CH_ZERO;
      return off[4:0];
    end else if (ch >= CH_LO_A && ch <= CH_LO_F) begin
      off = ch - CH_LO_A + 8'd10;
      return off[4:0];
    end else if (ch >= CH_UP_A && ch <= CH_UP_F) begin
      off = ch - CH_UP_A + 8'd10;
      return off[4:0];
    end
    return DIGIT_NONE;
  endfunction

  function automatic logic [4:0] radix_base(input radix_t r);
    case (r)
      RADIX_DEC: return 5'd10;
      RADIX_HEX: return 5'd16;
      RADIX_OCT: return 5'd8;
      RADIX_BIN: return 5'd2;
      default:   return 5'd10;
    endcase
  endfunction

  // Prefix letter lookup, either case.
  function automatic prefix_t prefix_lookup(input logic [7:0] ch);
    logic [7:0] lc;
    prefix_t    p;
    lc = (ch >= CH_UP_A && ch <= CH_UP_Z) ? (ch | 8'h20) : ch;
    p.valid = 1'b1;
    p.radix = RADIX_DEC;
    case (lc)
      CH_LO_X: p.radix = RADIX_HEX;
      CH_LO_D: p.radix = RADIX_DEC;
      CH_LO_O: p.radix = RADIX_OCT;
      CH_LO_B: p.radix = RADIX_BIN;
      default: p.valid = 1'b0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/ascii_integer_parser.sv]
// ASCII integer parser, top level: input register, parse state, result register.
// Depends on aip_pkg and aip_step.
//
// Usage: the input channel carries one character per transaction
// (in_character, in_last_char). A string is an optional + or - sign, an
// optional radix prefix (0x, 0d, 0o, 0b in either case, honored only when a
// character follows it) and digits. The transaction that carries
// in_last_char = 1 produces exactly one output transaction: out_value is the
// 32-bit pattern (two's complement when negative) and out_status is 1 on a
// syntax error or overflow, in which case out_value is 0. Other characters
// produce no output.
//
// Timing: one character is accepted per cycle while in_stall is low. A
// character is captured in the input register at its accepting edge and folded
// into the parse state by one shift-add-compare step. At the edge on which it
// leaves the input register, the state register and, for a final character,
// the result register load together, and out_valid rises with that load.
//
// Stall: when out_stall holds a result, a final character waiting in the
// input register cannot proceed and in_stall rises; non-final characters
// keep flowing since they produce no output. Reset (rst_n low, synchronous)
// empties both registers and returns the parse state to the start of a string.
`timescale 1ns / 1ps
`default_nettype none

module ascii_integer_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_character,
  input  wire logic        in_last_char,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_value,
  output logic             out_status
);

  // Input register.
  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic       s1_last_r;

  // Parse state carried between characters.
  aip_pkg::parse_state_t state_r;
  aip_pkg::parse_state_t state_nxt;
  aip_pkg::parse_state_t step_out;

  // Result register.
  logic        out_valid_r;
  logic [31:0] out_value_r;
  logic        out_status_r;
  logic [31:0] out_value_nxt;

  logic out_free;
  logic s1_go;
  logic in_take;

  assign out_free = !out_valid_r || !out_stall;
  // A staged character moves on unless it is final and the result slot is busy.
  assign s1_go    = s1_valid_r && (!s1_last_r || out_free);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_take  = in_valid && !in_stall;

  aip_step u_step (
    .cur  (state_r),
    .ch   (s1_char_r),
    .last (s1_last_r),
    .nxt  (step_out)
  );

  always_comb begin
    state_nxt = state_r;
    if (s1_go) begin
      state_nxt = s1_last_r ? aip_pkg::STATE_RESET : step_out;
    end
  end

  assign out_value_nxt = step_out.failed ? 32'd0 :
                         (step_out.negative ? (32'd0 - step_out.accum) : step_out.accum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= aip_pkg::STATE_RESET;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go && s1_last_r) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      state_r <= state_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_char_r <= in_character;
      s1_last_r <= in_last_char;
    end
    if (s1_go && s1_last_r) begin
      out_value_r  <= out_value_nxt;
      out_status_r <= step_out.failed;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  // An error result always carries a zero value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r |-> out_value_r == 32'd0)
    else $error("error result with nonzero value");

  // The parser only pushes back while it holds a character.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("stall raised with empty input register");

  // Finishing a string returns the parse state to its start.
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_last_r |=> state_r == aip_pkg::STATE_RESET && out_valid_r)
    else $error("state not cleared or result missing after final character");

  // A waiting result is never overwritten by a new final character.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !(s1_go && s1_last_r))
    else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

[hw/rtl/aip_step.sv]
// Next-state logic of the ASCII integer parser for one character.
// Depends on aip_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aip_step (
  input  wire aip_pkg::parse_state_t cur,
  input  wire logic [7:0]            ch,
  input  wire logic                  last,
  output aip_pkg::parse_state_t      nxt
);

  logic [4:0]       dig;
  logic [4:0]       base;
  logic [35:0]      scaled;
  logic [35:0]      sum;
  logic [35:0]      limit;
  aip_pkg::prefix_t pfx;
  logic             at_start;
  logic             before_digits;

  assign dig  = aip_pkg::digit_value(ch);
  assign base = aip_pkg::radix_base(cur.radix);
  assign pfx  = aip_pkg::prefix_lookup(ch);
  assign limit = cur.negative ? aip_pkg::LIMIT_NEG : aip_pkg::LIMIT_POS;
  assign at_start = (cur.phase == aip_pkg::PH_START);
  assign before_digits = at_start || (cur.phase == aip_pkg::PH_SIGN);

  // Multiply by the base with shifts; decimal is 8x + 2x.
  always_comb begin
    case (cur.radix)
      aip_pkg::RADIX_HEX: scaled = {cur.accum, 4'b0};
      aip_pkg::RADIX_OCT: scaled = {1'b0, cur.accum, 3'b0};
      aip_pkg::RADIX_BIN: scaled = {3'b0, cur.accum, 1'b0};
      default:            scaled = {1'b0, cur.accum, 3'b0} + {3'b0, cur.accum, 1'b0};
    endcase
  end

  assign sum = scaled + {31'd0, dig};

  always_comb begin
    nxt = cur;
    if (!cur.failed) begin
      if (at_start && (ch == aip_pkg::CH_MINUS || ch == aip_pkg::CH_PLUS)) begin
        nxt.failed   = last;
        nxt.negative = (ch == aip_pkg::CH_MINUS);
        nxt.phase    = aip_pkg::PH_SIGN;
      end else if (before_digits && ch == aip_pkg::CH_ZERO) begin
        nxt.accum = 32'd0;
        nxt.phase = aip_pkg::PH_ZERO;
      end else if (cur.phase == aip_pkg::PH_ZERO && !last && pfx.valid) begin
        nxt.radix = pfx.radix;
        nxt.phase = aip_pkg::PH_DIGITS;
      end else if (dig >= base || sum > limit) begin
        nxt.failed = 1'b1;
      end else begin
        nxt.accum = sum[31:0];
        nxt.phase = aip_pkg::PH_DIGITS;
      end
    end
  end

endmodule

`default_nettype wire
